// ===== hdl/ehfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ehfm_pkg
// Types, codes and reset values shared by the heartbeat and fault monitor.
// ----------------------------------------------------------------------------
package ehfm_pkg;

    localparam int NUM_ESC_DEF = 8;
    localparam int STATUS_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Item kinds
    localparam logic [1:0] CMD_TELEM = 2'd0;
    localparam logic [1:0] CMD_RATE  = 2'd1;
    localparam logic [1:0] CMD_HBEAT = 2'd2;

    // Result causes
    localparam logic [1:0] CAUSE_HBEAT = 2'd0;
    localparam logic [1:0] CAUSE_FAULT = 2'd1;
    localparam logic [1:0] CAUSE_RATE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MON_MASK   = 3'd6;

    // Reset values
    localparam logic signed [15:0] TEMP_LIMIT_RST = 16'sd900;
    localparam logic [15:0]        VOLT_LIMIT_RST = 16'd12000;
    localparam logic [14:0]        RATE_LIMIT_RST = 15'd5000;
    localparam logic [31:0]        TIMEOUT_RST    = 32'd1000;
    localparam logic [31:0]        GRACE_RST      = 32'd5000;
    localparam logic [31:0]        START_TIME_RST = 32'd0;
    localparam logic [7:0]         MON_MASK_RST   = 8'd255;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        time_ms;
        logic [2:0]         esc_id;
        logic signed [15:0] temperature_decideg;
        logic [15:0]        voltage_mv;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } in_item_t;

    typedef struct packed {
        logic                system_error;
        logic [1:0]          cause;
        logic [STATUS_W-1:0] stale_bits;
        logic [STATUS_W-1:0] fault_bits;
        logic                rate_fault_flag;
    } out_item_t;

    // Magnitude of a signed 16-bit rate; the most negative value needs 17 bits.
    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] sx;
        sx = {v[15], v};
        return v[15] ? 17'(-sx) : 17'(sx);
    endfunction

endpackage

// ===== hdl/ehfm_ram.sv =====
// ----------------------------------------------------------------------------
// ehfm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ehfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/esc_heartbeat_fault_monitor_core.sv =====
// ----------------------------------------------------------------------------
// esc_heartbeat_fault_monitor_core
// Heartbeat watchdog and temperature, voltage and body-rate fault monitor for
// up to NUM_ESC motor controllers.
// ----------------------------------------------------------------------------
//  Channel | Signals                        | Flow
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_item    | items, stall driven here
//  out     | out_valid, out_stall, out_item | results, stall driven by sink
//  cfg     | cfg_valid, cfg_ready, cfg_*    | register writes, always ready
//
//  A result reaches the output register through the execute and emit states,
//  or through execute, scan and emit for a heartbeat past the grace period,
//  where one age comparator walks the last-seen RAM one controller per cycle.
//  An item with no result frees the input when execute returns to idle. One item is in work at a time.
//  A finished result waits in the output register; the next item is taken
//  meanwhile, and a new result waits while out_stall holds the previous one.
//  Reset restores the register defaults and clears all flags; the last-seen
//  RAM is not cleared, since entries are only trusted once the seen bit is set.
// ----------------------------------------------------------------------------
module esc_heartbeat_fault_monitor_core #(
    parameter int NUM_ESC = ehfm_pkg::NUM_ESC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ehfm_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ehfm_pkg::out_item_t                 out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ehfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ehfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_ESC > 1) ? $clog2(NUM_ESC) : 1;
    localparam int VIS   = (NUM_ESC < ehfm_pkg::STATUS_W) ? NUM_ESC : ehfm_pkg::STATUS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    ehfm_pkg::out_item_t out_item_reg, out_item_next;
    ehfm_pkg::in_item_t  item_reg;
    logic [1:0]          cause_reg, cause_next;

    logic [NUM_ESC-1:0]  seen_reg, seen_next;
    logic [NUM_ESC-1:0]  stale_reg, stale_next;
    logic [NUM_ESC-1:0]  fault_reg, fault_next;
    logic                rate_fault_reg, rate_fault_next;

    logic signed [15:0]  temp_limit_reg, temp_limit_next;
    logic [15:0]         volt_limit_reg, volt_limit_next;
    logic [14:0]         rate_limit_reg, rate_limit_next;
    logic [31:0]         timeout_reg, timeout_next;
    logic [31:0]         grace_reg, grace_next;
    logic [31:0]         start_time_reg, start_time_next;
    logic [7:0]          mon_mask_reg, mon_mask_next;

    logic                accept;
    logic                cfg_we;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [31:0]         ram_rdata;
    logic [IDX_W-1:0]    tel_idx;
    logic                tel_in_range;
    logic [NUM_ESC-1:0]  tel_bit;
    logic                tel_bad;
    logic                rate_over;
    logic [NUM_ESC-1:0]  mon;
    logic                scan_last;

    // Shared unit: one wrapping subtract followed by one compare.
    logic [31:0]         unit_b;
    logic [31:0]         unit_lim;
    logic                unit_ge;
    logic [31:0]         unit_diff;
    logic                unit_hit;

    logic [ehfm_pkg::STATUS_W-1:0] stale_vis;
    logic [ehfm_pkg::STATUS_W-1:0] fault_vis;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    ehfm_ram #(
        .WIDTH(32),
        .DEPTH(NUM_ESC)
    ) u_last_seen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tel_idx),
        .wdata(item_reg.time_ms),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        tel_idx      = IDX_W'(item_reg.esc_id);
        tel_in_range = (32'(item_reg.esc_id) < 32'(NUM_ESC));
        tel_bit      = NUM_ESC'(1) << tel_idx;
        tel_bad      = (item_reg.temperature_decideg > temp_limit_reg) ||
                       (item_reg.voltage_mv < volt_limit_reg);
        rate_over    = (ehfm_pkg::abs16(item_reg.rate_x) > {2'b00, rate_limit_reg}) ||
                       (ehfm_pkg::abs16(item_reg.rate_y) > {2'b00, rate_limit_reg}) ||
                       (ehfm_pkg::abs16(item_reg.rate_z) > {2'b00, rate_limit_reg});
        mon          = (mon_mask_reg != 8'd0) ? NUM_ESC'(mon_mask_reg) : seen_reg;
        scan_last    = (cnt_reg == IDX_W'(NUM_ESC - 1));
    end

    // The grace check runs in the execute cycle, the age checks during the scan.
    always_comb
    begin
        unit_ge   = (state_reg == ST_EXEC);
        unit_b    = unit_ge ? start_time_reg : ram_rdata;
        unit_lim  = unit_ge ? grace_reg : timeout_reg;
        unit_diff = item_reg.time_ms - unit_b;
        unit_hit  = unit_ge ? (unit_diff >= unit_lim) : (unit_diff > unit_lim);
    end

    always_comb
    begin
        stale_vis = '0;
        fault_vis = '0;
        stale_vis[VIS-1:0] = stale_reg[VIS-1:0];
        fault_vis[VIS-1:0] = fault_reg[VIS-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cause_next      = cause_reg;
        seen_next       = seen_reg;
        stale_next      = stale_reg;
        fault_next      = fault_reg;
        rate_fault_next = rate_fault_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        ram_we          = 1'b0;
        ram_raddr       = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (item_reg.cmd)
                    ehfm_pkg::CMD_TELEM:
                    begin
                        if (tel_in_range)
                        begin
                            ram_we     = 1'b1;
                            seen_next  = seen_reg | tel_bit;
                            stale_next = stale_reg & ~tel_bit;
                            if (tel_bad)
                            begin
                                fault_next = fault_reg | tel_bit;
                                cause_next = ehfm_pkg::CAUSE_FAULT;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                fault_next = fault_reg & ~tel_bit;
                            end
                        end
                    end
                    ehfm_pkg::CMD_RATE:
                    begin
                        rate_fault_next = rate_over;
                        if (rate_over && !rate_fault_reg)
                        begin
                            cause_next = ehfm_pkg::CAUSE_RATE;
                            state_next = ST_EMIT;
                        end
                    end
                    ehfm_pkg::CMD_HBEAT:
                    begin
                        cause_next = ehfm_pkg::CAUSE_HBEAT;
                        cnt_next   = '0;
                        ram_raddr  = '0;
                        state_next = unit_hit ? ST_SCAN : ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                ram_raddr = scan_last ? '0 : IDX_W'(cnt_reg + 1'b1);
                if (mon[cnt_reg] && (!seen_reg[cnt_reg] || unit_hit))
                begin
                    stale_next[cnt_reg] = 1'b1;
                end
                if (scan_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = IDX_W'(cnt_reg + 1'b1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.cause           = cause_reg;
                    out_item_next.system_error    = (cause_reg != ehfm_pkg::CAUSE_HBEAT) ||
                                                    (fault_reg != '0) || (stale_reg != '0) ||
                                                    rate_fault_reg;
                    out_item_next.stale_bits      = stale_vis;
                    out_item_next.fault_bits      = fault_vis;
                    out_item_next.rate_fault_flag = rate_fault_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        temp_limit_next = temp_limit_reg;
        volt_limit_next = volt_limit_reg;
        rate_limit_next = rate_limit_reg;
        timeout_next    = timeout_reg;
        grace_next      = grace_reg;
        start_time_next = start_time_reg;
        mon_mask_next   = mon_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ehfm_pkg::REG_TEMP_LIMIT: temp_limit_next = cfg_data[15:0];
                ehfm_pkg::REG_VOLT_LIMIT: volt_limit_next = cfg_data[15:0];
                ehfm_pkg::REG_RATE_LIMIT: rate_limit_next = cfg_data[14:0];
                ehfm_pkg::REG_TIMEOUT:    timeout_next    = cfg_data;
                ehfm_pkg::REG_GRACE:      grace_next      = cfg_data;
                ehfm_pkg::REG_START_TIME: start_time_next = cfg_data;
                ehfm_pkg::REG_MON_MASK:   mon_mask_next   = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            seen_reg       <= '0;
            stale_reg      <= '0;
            fault_reg      <= '0;
            rate_fault_reg <= 1'b0;
            temp_limit_reg <= ehfm_pkg::TEMP_LIMIT_RST;
            volt_limit_reg <= ehfm_pkg::VOLT_LIMIT_RST;
            rate_limit_reg <= ehfm_pkg::RATE_LIMIT_RST;
            timeout_reg    <= ehfm_pkg::TIMEOUT_RST;
            grace_reg      <= ehfm_pkg::GRACE_RST;
            start_time_reg <= ehfm_pkg::START_TIME_RST;
            mon_mask_reg   <= ehfm_pkg::MON_MASK_RST;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            seen_reg       <= seen_next;
            stale_reg      <= stale_next;
            fault_reg      <= fault_next;
            rate_fault_reg <= rate_fault_next;
            temp_limit_reg <= temp_limit_next;
            volt_limit_reg <= volt_limit_next;
            rate_limit_reg <= rate_limit_next;
            timeout_reg    <= timeout_next;
            grace_reg      <= grace_next;
            start_time_reg <= start_time_next;
            mon_mask_reg   <= mon_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        cause_reg    <= cause_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ===== hdl/ehfm_checker.sv =====
// ----------------------------------------------------------------------------
// ehfm_checker
// Port-level checks for the heartbeat and fault monitor, bound to the core.
// ----------------------------------------------------------------------------
module ehfm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input ehfm_pkg::out_item_t             out_item
);

    // A result held back by the sink stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

    // Work on an item keeps the input stalled in the cycle after the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

    // Fault and rate reports always signal an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.cause == ehfm_pkg::CAUSE_FAULT ||
                      out_item.cause == ehfm_pkg::CAUSE_RATE) |-> out_item.system_error)
    else $error("fault report without error flag");

    // A rate report is only made while the rate fault is set, and any visible
    // flag in a heartbeat report means error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_item.cause == ehfm_pkg::CAUSE_RATE && !out_item.rate_fault_flag) ||
                      (out_item.cause == ehfm_pkg::CAUSE_HBEAT && !out_item.system_error &&
                       (out_item.stale_bits != '0 || out_item.fault_bits != '0 ||
                        out_item.rate_fault_flag))) |-> 1'b0)
    else $error("reported flags disagree with reported state");

endmodule

bind esc_heartbeat_fault_monitor_core ehfm_checker u_ehfm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
);
